### rtl/gimli_pkg.sv
// ----------------------------------------------------------------------------
// gimli_pkg
// Types, constants and the round function shared by the Gimli permutation
// pipeline.
// ----------------------------------------------------------------------------
package gimli_pkg;

    localparam int WORD_W         = 32;
    localparam int NUM_WORDS      = 12;
    localparam int ROUND_W        = 5;
    localparam int ROUNDS_DEFAULT = 24;

    localparam logic [WORD_W-1:0] ROUND_CONST = 32'h9e37_7900;

    typedef logic [WORD_W-1:0]                 word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  state_t;
    typedef logic [ROUND_W-1:0]                round_t;

    typedef struct packed {
        word_t word_in_0;
        word_t word_in_1;
        word_t word_in_2;
        word_t word_in_3;
        word_t word_in_4;
        word_t word_in_5;
        word_t word_in_6;
        word_t word_in_7;
        word_t word_in_8;
        word_t word_in_9;
        word_t word_in_10;
        word_t word_in_11;
    } state_in_t;

    typedef struct packed {
        word_t word_out_0;
        word_t word_out_1;
        word_t word_out_2;
        word_t word_out_3;
        word_t word_out_4;
        word_t word_out_5;
        word_t word_out_6;
        word_t word_out_7;
        word_t word_out_8;
        word_t word_out_9;
        word_t word_out_10;
        word_t word_out_11;
    } state_out_t;

    // One full round: SP-box on all four columns, then the swap that the
    // round number selects, plus the round constant on rounds that are multiples of four.
    function automatic state_t gimli_round(input state_t s, input round_t r);
        state_t res;
        word_t  x;
        word_t  y;
        word_t  z;
        word_t  t;
        res = s;
        for (int c = 0; c < 4; c++)
        begin
            x = {s[c][7:0], s[c][31:8]};
            y = {s[4+c][22:0], s[4+c][31:23]};
            z = s[8+c];
            res[8+c] = x ^ (z << 1) ^ ((y & z) << 2);
            res[4+c] = y ^ x ^ ((x | z) << 1);
            res[c]   = z ^ y ^ ((x & y) << 3);
        end
        if (r[1:0] == 2'd0)
        begin
            t      = res[0];
            res[0] = res[1];
            res[1] = t;
            t      = res[2];
            res[2] = res[3];
            res[3] = t;
            res[0] = res[0] ^ ROUND_CONST ^ {{(WORD_W-ROUND_W){1'b0}}, r};
        end
        else if (r[1:0] == 2'd2)
        begin
            t      = res[0];
            res[0] = res[2];
            res[2] = t;
            t      = res[1];
            res[1] = res[3];
            res[3] = t;
        end
        return res;
    endfunction

endpackage

### rtl/gimli_round_stage.sv
// ----------------------------------------------------------------------------
// gimli_round_stage
// One pipeline stage: applies a single Gimli round and registers the state
// with its valid bit. Loads when empty or when the next stage drains it.
// ----------------------------------------------------------------------------
module gimli_round_stage
    import gimli_pkg::*;
#(
    parameter round_t ROUND_NUM = round_t'(ROUNDS_DEFAULT)
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    input  state_t up_data,
    output logic   up_ready,
    output logic   valid,
    output state_t data,
    input  logic   down_ready
);

    logic   valid_reg;
    state_t data_reg;
    state_t data_next;

    assign data_next = gimli_round(up_data, ROUND_NUM);
    assign up_ready  = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // payload: hold unless a new word moves in
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### rtl/gimli_permutation_core.sv
// ----------------------------------------------------------------------------
// gimli_permutation_core
// Gimli-384 permutation, fully unrolled: one register stage per round, rounds
// ROUNDS down to 1. A new 384-bit word is accepted every cycle while req_stall
// is low; its result appears on rsp_data after it passes every round stage.
// Each stage holds its word while the stage after it is full and stalled, so
// bubbles close up and a stall at the output backs up to the input only once
// every stage is occupied.
// ----------------------------------------------------------------------------
module gimli_permutation_core
    import gimli_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  state_in_t  req_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output state_out_t rsp_data
);

    state_t stage_data  [ROUNDS+1];
    logic   stage_valid [ROUNDS+1];
    logic   stage_ready [ROUNDS+1];
    state_t final_state;

    // state index i carries state word i: row x at 0..3, row y at 4..7, row z at 8..11
    assign stage_data[0]  = {req_data.word_in_11, req_data.word_in_10,
                             req_data.word_in_9,  req_data.word_in_8,
                             req_data.word_in_7,  req_data.word_in_6,
                             req_data.word_in_5,  req_data.word_in_4,
                             req_data.word_in_3,  req_data.word_in_2,
                             req_data.word_in_1,  req_data.word_in_0};
    assign stage_valid[0] = req_valid;
    assign req_stall      = !stage_ready[0];

    genvar k;
    generate
        for (k = 0; k < ROUNDS; k++)
        begin : g_round
            gimli_round_stage #(
                .ROUND_NUM (round_t'(ROUNDS - k))
            ) u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .up_valid   (stage_valid[k]),
                .up_data    (stage_data[k]),
                .up_ready   (stage_ready[k]),
                .valid      (stage_valid[k+1]),
                .data       (stage_data[k+1]),
                .down_ready (stage_ready[k+1])
            );
        end
    endgenerate

    assign stage_ready[ROUNDS] = !rsp_stall;
    assign final_state         = stage_data[ROUNDS];
    assign rsp_valid           = stage_valid[ROUNDS];

    always_comb
    begin
        rsp_data.word_out_0  = final_state[0];
        rsp_data.word_out_1  = final_state[1];
        rsp_data.word_out_2  = final_state[2];
        rsp_data.word_out_3  = final_state[3];
        rsp_data.word_out_4  = final_state[4];
        rsp_data.word_out_5  = final_state[5];
        rsp_data.word_out_6  = final_state[6];
        rsp_data.word_out_7  = final_state[7];
        rsp_data.word_out_8  = final_state[8];
        rsp_data.word_out_9  = final_state[9];
        rsp_data.word_out_10 = final_state[10];
        rsp_data.word_out_11 = final_state[11];
    end

endmodule
